[src/xsr_pkg.sv]
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared types and constants for the xoshiro256** random unit: payload
// structs, command codes, datapath operations and mixing constants.
// ----------------------------------------------------------------------------
package xsr_pkg;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int INT_W   = 32;
    localparam int PROB_W  = 54;
    localparam int FRAC_W  = 53;
    localparam int RANGE_W = INT_W + 1;
    localparam int NUM_WORDS = 4;
    localparam int WIDX_W  = $clog2(NUM_WORDS);

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;

    // request command codes
    localparam logic [1:0] CMD_RAW    = 2'd0;
    localparam logic [1:0] CMD_INT    = 2'd1;
    localparam logic [1:0] CMD_BERN   = 2'd2;
    localparam logic [1:0] CMD_RESEED = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [INT_W-1:0] low_bound;
        logic signed [INT_W-1:0] high_bound;
        logic [PROB_W-1:0]       probability;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]       raw_value;
        logic signed [INT_W-1:0] int_value;
        logic                    hit;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SM_ADD,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_MIX,
        OP_STORE,
        OP_GEN1,
        OP_GEN2,
        OP_DIV,
        OP_PUBLISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic              mul_b;
        logic [WIDX_W-1:0] word_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       draw;
    } dp_stat_t;

endpackage

[src/xoshiro256ss_random_unit.sv]
// ----------------------------------------------------------------------------
// xoshiro256ss_random_unit
// Xoshiro256** generator with splitmix64 seeding, raw, integer range and
// Bernoulli draws.
// ----------------------------------------------------------------------------
// One request is worked at a time, and its result sits in an output register
// so a new request is taken while the last result waits. A raw draw and a
// Bernoulli draw that draws pass through the two-step generator advance; an
// empty-range integer draw and a Bernoulli draw with probability zero or one
// go straight to hand-off; an integer draw adds the 64-step restoring
// remainder unit after the advance; a reseed runs four splitmix64 rounds that
// each use the one 32x32 multiplier six times. The result is written to the
// output register at hand-off, and a result still held in the output register
// holds the next request in its hand-off state until that result leaves.
// After reset the unit runs the seed-zero expansion with in_ready low; seed
// writes are taken at any time and only a reseed request uses the value.
module xoshiro256ss_random_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       seed_wr_en,
    input  logic [xsr_pkg::WORD_W-1:0] seed_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  xsr_pkg::in_item_t          in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output xsr_pkg::out_item_t         out_data
);

    xsr_pkg::dp_cmd_t  dp_cmd;
    xsr_pkg::dp_stat_t dp_stat;

    xsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    xsr_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_wr_en   (seed_wr_en),
        .seed_wr_data (seed_wr_data),
        .in_data      (in_data),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .out_data     (out_data)
    );

endmodule

[src/xsr_ctrl.sv]
// ----------------------------------------------------------------------------
// xsr_ctrl
// Sequencer for the random unit: steps the datapath through seeding,
// generator advance, remainder steps and result hand-off.
// ----------------------------------------------------------------------------
module xsr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  xsr_pkg::dp_stat_t stat,
    output xsr_pkg::dp_cmd_t  cmd
);

    localparam int DIV_STEPS = xsr_pkg::WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [xsr_pkg::WIDX_W-1:0] WIDX_LAST =
        xsr_pkg::WIDX_W'(xsr_pkg::NUM_WORDS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SM_ADD,
        S_MA_LL,
        S_MA_LH,
        S_MA_HL,
        S_MIX,
        S_MB_LL,
        S_MB_LH,
        S_MB_HL,
        S_STORE,
        S_GEN1,
        S_GEN2,
        S_DIV,
        S_FIN
    } state_t;

    state_t                     state_reg, state_next;
    logic [xsr_pkg::WIDX_W-1:0] widx_reg, widx_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       init_reg, init_next;
    logic [1:0]                 cmd_reg, cmd_next;
    logic                       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        widx_next      = widx_reg;
        cnt_next       = cnt_reg;
        init_next      = init_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = xsr_pkg::OP_NONE;
        cmd.mul_b      = 1'b0;
        cmd.word_idx   = widx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op   = xsr_pkg::OP_LOAD;
                    cmd_next = stat.command;
                    if (stat.command == xsr_pkg::CMD_RESEED)
                    begin
                        widx_next  = '0;
                        state_next = S_SM_ADD;
                    end
                    else if (stat.draw)
                    begin
                        state_next = S_GEN1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_SM_ADD:
            begin
                cmd.op     = xsr_pkg::OP_SM_ADD;
                state_next = S_MA_LL;
            end
            S_MA_LL:
            begin
                cmd.op     = xsr_pkg::OP_MUL_LL;
                state_next = S_MA_LH;
            end
            S_MA_LH:
            begin
                cmd.op     = xsr_pkg::OP_MUL_LH;
                state_next = S_MA_HL;
            end
            S_MA_HL:
            begin
                cmd.op     = xsr_pkg::OP_MUL_HL;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.op     = xsr_pkg::OP_MIX;
                state_next = S_MB_LL;
            end
            S_MB_LL:
            begin
                cmd.op     = xsr_pkg::OP_MUL_LL;
                cmd.mul_b  = 1'b1;
                state_next = S_MB_LH;
            end
            S_MB_LH:
            begin
                cmd.op     = xsr_pkg::OP_MUL_LH;
                cmd.mul_b  = 1'b1;
                state_next = S_MB_HL;
            end
            S_MB_HL:
            begin
                cmd.op     = xsr_pkg::OP_MUL_HL;
                cmd.mul_b  = 1'b1;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.op = xsr_pkg::OP_STORE;
                if (widx_reg == WIDX_LAST)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    widx_next  = widx_reg + 1'b1;
                    state_next = S_SM_ADD;
                end
            end
            S_GEN1:
            begin
                cmd.op     = xsr_pkg::OP_GEN1;
                state_next = S_GEN2;
            end
            S_GEN2:
            begin
                cmd.op = xsr_pkg::OP_GEN2;
                if (cmd_reg == xsr_pkg::CMD_INT)
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                cmd.op   = xsr_pkg::OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // the power-up seeding pass produces no result
                if (init_reg)
                begin
                    init_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = xsr_pkg::OP_PUBLISH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SM_ADD;
            widx_reg      <= '0;
            cnt_reg       <= '0;
            init_reg      <= 1'b1;
            cmd_reg       <= xsr_pkg::CMD_RAW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            widx_reg      <= widx_next;
            cnt_reg       <= cnt_next;
            init_reg      <= init_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[src/xsr_dpath.sv]
// ----------------------------------------------------------------------------
// xsr_dpath
// Datapath of the random unit: generator words, splitmix seeding with a
// shared 32x32 multiplier, output scrambler, restoring remainder unit and
// the output register.
// ----------------------------------------------------------------------------
module xsr_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seed_wr_en,
    input  logic [xsr_pkg::WORD_W-1:0]  seed_wr_data,
    input  xsr_pkg::in_item_t           in_data,
    input  xsr_pkg::dp_cmd_t            cmd,
    output xsr_pkg::dp_stat_t           stat,
    output xsr_pkg::out_item_t          out_data
);

    localparam int W  = xsr_pkg::WORD_W;
    localparam int H  = xsr_pkg::HALF_W;
    localparam int IW = xsr_pkg::INT_W;
    localparam int RW = xsr_pkg::RANGE_W;

    function automatic logic [W-1:0] rotl(input logic [W-1:0] v, input int k);
        rotl = (v << k) | (v >> (W - k));
    endfunction

    logic [W-1:0]            seed_reg;
    logic [W-1:0]            s_reg;
    logic [W-1:0]            z_reg;
    logic [W-1:0]            acc_reg;
    logic [W-1:0]            w_reg [xsr_pkg::NUM_WORDS];
    logic [W-1:0]            t_reg;
    logic [W-1:0]            raw_reg;
    logic [IW-1:0]           rem_reg;
    logic [RW-1:0]           range_reg;
    logic [1:0]              command_reg;
    logic                    draw_reg;
    logic [IW-1:0]           lo_reg;
    logic [xsr_pkg::PROB_W-1:0] p_reg;
    xsr_pkg::out_item_t      out_reg;

    // incoming request status
    logic in_empty;
    always_comb
    begin
        in_empty     = (in_data.low_bound > in_data.high_bound);
        stat.command = in_data.command;
        unique case (in_data.command)
            xsr_pkg::CMD_RAW:  stat.draw = 1'b1;
            xsr_pkg::CMD_INT:  stat.draw = !in_empty;
            xsr_pkg::CMD_BERN: stat.draw = (in_data.probability != '0) &&
                                           !in_data.probability[xsr_pkg::FRAC_W];
            default:           stat.draw = 1'b0;
        endcase
    end

    // shared multiplier: z times mixing constant, low 64 bits over three steps
    logic [W-1:0] mconst;
    logic [H-1:0] mul_a, mul_b;
    logic [W-1:0] prod;
    always_comb
    begin
        mconst = cmd.mul_b ? xsr_pkg::MIX_MUL_B : xsr_pkg::MIX_MUL_A;
        unique case (cmd.op)
            xsr_pkg::OP_MUL_LH:
            begin
                mul_a = z_reg[H-1:0];
                mul_b = mconst[W-1:H];
            end
            xsr_pkg::OP_MUL_HL:
            begin
                mul_a = z_reg[W-1:H];
                mul_b = mconst[H-1:0];
            end
            default:
            begin
                mul_a = z_reg[H-1:0];
                mul_b = mconst[H-1:0];
            end
        endcase
        prod = W'(mul_a) * W'(mul_b);
    end

    logic [W-1:0] s_sum;
    assign s_sum = s_reg + xsr_pkg::GOLDEN_STEP;

    // generator advance and scrambler
    logic [W-1:0] n0, n1, n2, n3, sh17, scr;
    always_comb
    begin
        sh17 = w_reg[1] << 17;
        n2   = w_reg[2] ^ w_reg[0];
        n3   = w_reg[3] ^ w_reg[1];
        n1   = w_reg[1] ^ n2;
        n0   = w_reg[0] ^ n3;
        n2   = n2 ^ sh17;
        n3   = rotl(n3, 45);
        scr  = rotl(t_reg, 7);
    end

    // restoring remainder step
    logic [RW-1:0] trial, diff;
    always_comb
    begin
        trial = {rem_reg, t_reg[W-1]};
        diff  = trial - range_reg;
    end

    // result at hand-off
    xsr_pkg::out_item_t result;
    always_comb
    begin
        result.raw_value = raw_reg;
        result.int_value = '0;
        result.hit       = 1'b0;
        if (command_reg == xsr_pkg::CMD_INT)
        begin
            result.int_value = draw_reg ? (lo_reg + rem_reg) : lo_reg;
        end
        if (command_reg == xsr_pkg::CMD_BERN)
        begin
            priority if (p_reg[xsr_pkg::FRAC_W])
                result.hit = 1'b1;
            else if (p_reg == '0)
                result.hit = 1'b0;
            else
                result.hit = (raw_reg[W-1:W-xsr_pkg::FRAC_W] < p_reg[xsr_pkg::FRAC_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            s_reg    <= '0;
        end
        else
        begin
            if (seed_wr_en)
                seed_reg <= seed_wr_data;
            if (cmd.op == xsr_pkg::OP_LOAD)
                s_reg <= seed_reg;
            else if (cmd.op == xsr_pkg::OP_SM_ADD)
                s_reg <= s_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            xsr_pkg::OP_LOAD:
            begin
                command_reg <= in_data.command;
                draw_reg    <= stat.draw;
                lo_reg      <= in_data.low_bound;
                p_reg       <= in_data.probability;
                range_reg   <= RW'({in_data.high_bound[IW-1], in_data.high_bound}
                                   - {in_data.low_bound[IW-1], in_data.low_bound}
                                   + RW'(1));
                raw_reg     <= '0;
                rem_reg     <= '0;
            end
            xsr_pkg::OP_SM_ADD:
            begin
                z_reg <= s_sum ^ (s_sum >> 30);
            end
            xsr_pkg::OP_MUL_LL:
            begin
                acc_reg <= prod;
            end
            xsr_pkg::OP_MUL_LH, xsr_pkg::OP_MUL_HL:
            begin
                acc_reg <= acc_reg + {prod[H-1:0], {H{1'b0}}};
            end
            xsr_pkg::OP_MIX:
            begin
                z_reg <= acc_reg ^ (acc_reg >> 27);
            end
            xsr_pkg::OP_STORE:
            begin
                w_reg[cmd.word_idx] <= acc_reg ^ (acc_reg >> 31);
            end
            xsr_pkg::OP_GEN1:
            begin
                t_reg    <= w_reg[1] + (w_reg[1] << 2);
                w_reg[0] <= n0;
                w_reg[1] <= n1;
                w_reg[2] <= n2;
                w_reg[3] <= n3;
            end
            xsr_pkg::OP_GEN2:
            begin
                raw_reg <= scr + (scr << 3);
                t_reg   <= scr + (scr << 3);
            end
            xsr_pkg::OP_DIV:
            begin
                rem_reg <= (trial >= range_reg) ? diff[IW-1:0] : trial[IW-1:0];
                t_reg   <= t_reg << 1;
            end
            xsr_pkg::OP_PUBLISH:
            begin
                out_reg <= result;
            end
            default:
            begin
            end
        endcase
    end

    assign out_data = out_reg;

endmodule
